// ===== design/stnh_pkg.sv =====
// shared constants and port layout for the spanning-tree next-hop router
package stnh_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;
  localparam int COST_BITS_DEF = 16;

  localparam int VERT_W     = 6;
  localparam int COST_IN_W  = 16;
  localparam int NCOUNT_W   = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES  = 1'b1;

  localparam logic [NCOUNT_W-1:0] NODES_RESET = 7'd64;

endpackage

// ===== design/stnh_ram.sv =====
// single-port-write, single-port-read memory with registered read data
module stnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spanning_tree_next_hop_router.sv =====
// top level: edge loading, kruskal tree build and next-hop lookup
//
// in_* channel: one request per beat. in_tuser is the mode: load an edge or
//   query a destination. in_tlast on a load marks the final edge and starts
//   the tree build. in_tdata: end_a, end_b, edge_cost, destination.
// out_* channel: one result per query request (next_hop, found); loads
//   produce nothing.
// cfg_* channel: register writes (source_node, node_count), always ready;
//   write only while no request is in flight.
// flow: a query reaches its result register through the hop memory read,
//   then the output register. a load with tlast is followed by a busy
//   build: a clearing sweep over max(MAX_NODES, MAX_EDGES) entries, then per
//   kept-or-rejected edge one scan of all edges, a read and a check state per
//   union-find step and a link state, then, if the source is in range,
//   rooting passes that read each edge and, for a tree edge, the hop entries
//   of both ends, until a pass changes no hop entry. all of it runs through
//   single-write, single-read memories under one sequencer.
// reset: synchronous rst_n clears control state; no tree is ready, so
//   queries answer not found. edge memory content is left as it was.
// stall: a result waits in the output register until out_tready; a new
//   request is taken once the result register is free or draining.
module spanning_tree_next_hop_router #(
  parameter int MAX_NODES = stnh_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = stnh_pkg::MAX_EDGES_DEF,
  parameter int COST_BITS = stnh_pkg::COST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // end_a[5:0], end_b[11:6], edge_cost[27:12], destination[33:28], zero pad
  input  logic [stnh_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // next_hop[5:0], found[6], zero pad
  output logic [stnh_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stnh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VW   = stnh_pkg::VERT_W;
  localparam int NIW  = $clog2(MAX_NODES);
  localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int EW   = 2 * VW + COST_BITS;
  localparam int HW   = VW + 1;
  localparam int CLRN = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int CW   = $clog2(CLRN + 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_QRY   = 11'b00000000010,
    ST_CLR   = 11'b00000000100,
    ST_SCAN  = 11'b00000001000,
    ST_FRD   = 11'b00000010000,
    ST_FCK   = 11'b00000100000,
    ST_LINK  = 11'b00001000000,
    ST_HISS  = 11'b00010000000,
    ST_HEDGE = 11'b00100000000,
    ST_HHA   = 11'b01000000000,
    ST_HHB   = 11'b10000000000
  } state_t;

  // request fields
  logic [VW-1:0]        f_a, f_b, f_dest;
  logic [COST_BITS-1:0] f_cost;
  assign f_a    = in_tdata[5:0];
  assign f_b    = in_tdata[11:6];
  assign f_cost = COST_BITS'(in_tdata[27:12]);
  assign f_dest = in_tdata[33:28];

  state_t state_r, state_nxt;

  // configuration
  logic [VW-1:0]                 source_r;
  logic [stnh_pkg::NCOUNT_W-1:0] nodes_r;

  // control and sequencer registers
  logic [ECW-1:0] total_r, total_nxt;
  logic           ready_r, ready_nxt;
  logic [VW-1:0]  src_r, src_nxt;
  logic           src_ok_r, src_ok_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  logic [ECW-1:0] sc_r, sc_nxt;
  logic           pend_r, pend_nxt;
  logic [EIW-1:0] pidx_r, pidx_nxt;
  logic                 best_v_r, best_v_nxt;
  logic [COST_BITS-1:0] best_cost_r, best_cost_nxt;
  logic [EIW-1:0]       best_idx_r, best_idx_nxt;
  logic [VW-1:0]        best_a_r, best_a_nxt, best_b_r, best_b_nxt;
  logic                 last_v_r, last_v_nxt;
  logic [COST_BITS-1:0] last_cost_r, last_cost_nxt;
  logic [EIW-1:0]       last_idx_r, last_idx_nxt;
  logic           side_r, side_nxt;
  logic [VW-1:0]  cur_r, cur_nxt, ra_r, ra_nxt;
  logic [ECW-1:0] j_r, j_nxt;
  logic           chg_r, chg_nxt;
  logic [VW-1:0]  ea_r, ea_nxt, eb_r, eb_nxt;
  logic [HW-1:0]  hopa_r, hopa_nxt;
  logic           qok_r, qok_nxt;
  logic           out_v_r, out_v_nxt;
  logic [VW-1:0]  out_hop_r, out_hop_nxt;
  logic           out_fnd_r, out_fnd_nxt;

  // memory ports
  logic           e_we;
  logic [EIW-1:0] e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           p_we;
  logic [NIW-1:0] p_waddr, p_raddr;
  logic [VW-1:0]  p_wdata, p_rdata;
  logic           m_we;
  logic [EIW-1:0] m_waddr;
  logic           m_wdata, m_rdata;
  logic           h_we;
  logic [NIW-1:0] h_waddr, h_raddr;
  logic [HW-1:0]  h_wdata, h_rdata;

  stnh_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EIW)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  stnh_ram #(.WIDTH(VW), .DEPTH(MAX_NODES), .AW(NIW)) u_parent_ram (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );
  stnh_ram #(.WIDTH(1), .DEPTH(MAX_EDGES), .AW(EIW)) u_mark_ram (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(e_raddr), .rdata(m_rdata)
  );
  stnh_ram #(.WIDTH(HW), .DEPTH(MAX_NODES), .AW(NIW)) u_hop_ram (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  // edge word fields as read back
  logic [VW-1:0]        rd_a, rd_b;
  logic [COST_BITS-1:0] rd_cost;
  assign rd_a    = e_rdata[VW-1:0];
  assign rd_b    = e_rdata[2*VW-1:VW];
  assign rd_cost = e_rdata[EW-1:2*VW];

  // handshakes
  assign in_tready  = (state_r == ST_IDLE) && (!out_v_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_fnd_r, out_hop_r};

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_r <= '0;
      nodes_r  <= stnh_pkg::NODES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stnh_pkg::REG_SOURCE: source_r <= cfg_data[VW-1:0];
        stnh_pkg::REG_NODES:  source_r <= source_r;
        default:              source_r <= source_r;
      endcase
      if (cfg_index == stnh_pkg::REG_NODES) begin
        nodes_r <= cfg_data;
      end
    end
  end

  // sequencer
  always_comb begin
    logic [ECW-1:0] tot_eff;
    logic           a_ok, b_ok, keep, after, take;
    logic           ra_reach, rb_reach;

    state_nxt     = state_r;
    total_nxt     = total_r;
    ready_nxt     = ready_r;
    src_nxt       = src_r;
    src_ok_nxt    = src_ok_r;
    clr_nxt       = clr_r;
    sc_nxt        = sc_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    best_v_nxt    = best_v_r;
    best_cost_nxt = best_cost_r;
    best_idx_nxt  = best_idx_r;
    best_a_nxt    = best_a_r;
    best_b_nxt    = best_b_r;
    last_v_nxt    = last_v_r;
    last_cost_nxt = last_cost_r;
    last_idx_nxt  = last_idx_r;
    side_nxt      = side_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    j_nxt         = j_r;
    chg_nxt       = chg_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    hopa_nxt      = hopa_r;
    qok_nxt       = qok_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_hop_nxt   = out_hop_r;
    out_fnd_nxt   = out_fnd_r;

    e_we    = 1'b0;
    e_waddr = '0;
    e_wdata = {f_cost, f_b, f_a};
    e_raddr = EIW'(sc_r);
    p_we    = 1'b0;
    p_waddr = NIW'(clr_r);
    p_wdata = VW'(clr_r);
    p_raddr = NIW'(cur_r);
    m_we    = 1'b0;
    m_waddr = EIW'(clr_r);
    m_wdata = 1'b0;
    h_we    = 1'b0;
    h_waddr = NIW'(clr_r);
    h_wdata = '0;
    h_raddr = NIW'(f_dest);

    tot_eff  = ready_r ? '0 : total_r;
    a_ok     = (32'(f_a) < 32'(nodes_r)) && (32'(f_a) < 32'(MAX_NODES));
    b_ok     = (32'(f_b) < 32'(nodes_r)) && (32'(f_b) < 32'(MAX_NODES));
    keep     = a_ok && b_ok && (32'(tot_eff) < 32'(MAX_EDGES));
    after    = !last_v_r || (rd_cost > last_cost_r) ||
               ((rd_cost == last_cost_r) && (pidx_r > last_idx_r));
    take     = pend_r && after && (!best_v_r || (rd_cost < best_cost_r));
    ra_reach = (ea_r == src_r) || hopa_r[VW];
    rb_reach = (eb_r == src_r) || h_rdata[VW];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == stnh_pkg::MODE_QUERY) begin
            qok_nxt   = ready_r && (32'(f_dest) < 32'(MAX_NODES));
            state_nxt = ST_QRY;
          end else begin
            ready_nxt = 1'b0;
            e_we      = keep;
            e_waddr   = EIW'(tot_eff);
            total_nxt = tot_eff + ECW'(keep);
            if (in_tlast) begin
              src_nxt    = source_r;
              src_ok_nxt = 32'(source_r) < 32'(MAX_NODES);
              clr_nxt    = '0;
              state_nxt  = ST_CLR;
            end
          end
        end
      end
      ST_QRY: begin
        out_v_nxt   = 1'b1;
        out_fnd_nxt = qok_r && h_rdata[VW];
        out_hop_nxt = (qok_r && h_rdata[VW]) ? h_rdata[VW-1:0] : '0;
        state_nxt   = ST_IDLE;
      end
      ST_CLR: begin
        // parents to self, hop entries unreachable, tree marks clear
        p_we = 32'(clr_r) < 32'(MAX_NODES);
        h_we = 32'(clr_r) < 32'(MAX_NODES);
        m_we = 32'(clr_r) < 32'(MAX_EDGES);
        if (32'(clr_r) == 32'(CLRN - 1)) begin
          sc_nxt     = '0;
          best_v_nxt = 1'b0;
          last_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end else begin
          clr_nxt = clr_r + CW'(1);
        end
      end
      ST_SCAN: begin
        // find the next edge in (cost, load order)
        if (take) begin
          best_v_nxt    = 1'b1;
          best_cost_nxt = rd_cost;
          best_idx_nxt  = pidx_r;
          best_a_nxt    = rd_a;
          best_b_nxt    = rd_b;
        end
        if (sc_r < total_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = EIW'(sc_r);
          sc_nxt   = sc_r + ECW'(1);
        end else if (!pend_r) begin
          if (best_v_r) begin
            last_v_nxt    = 1'b1;
            last_cost_nxt = best_cost_r;
            last_idx_nxt  = best_idx_r;
            side_nxt      = 1'b0;
            cur_nxt       = best_a_r;
            state_nxt     = ST_FRD;
          end else begin
            j_nxt     = '0;
            chg_nxt   = 1'b0;
            state_nxt = src_ok_r ? ST_HISS : ST_IDLE;
            ready_nxt = !src_ok_r;
          end
        end
      end
      ST_FRD: begin
        state_nxt = ST_FCK;
      end
      ST_FCK: begin
        if (p_rdata == cur_r) begin
          if (!side_r) begin
            ra_nxt    = cur_r;
            side_nxt  = 1'b1;
            cur_nxt   = best_b_r;
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_LINK;
          end
        end else begin
          cur_nxt   = p_rdata;
          state_nxt = ST_FRD;
        end
      end
      ST_LINK: begin
        // cur_r holds the root of end b
        p_we       = ra_r != cur_r;
        p_waddr    = NIW'(ra_r);
        p_wdata    = cur_r;
        m_we       = ra_r != cur_r;
        m_waddr    = best_idx_r;
        m_wdata    = 1'b1;
        sc_nxt     = '0;
        best_v_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      ST_HISS: begin
        e_raddr = EIW'(j_r);
        if (j_r == total_r) begin
          if (chg_r) begin
            j_nxt   = '0;
            chg_nxt = 1'b0;
          end else begin
            ready_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_HEDGE;
        end
      end
      ST_HEDGE: begin
        h_raddr = NIW'(rd_a);
        ea_nxt  = rd_a;
        eb_nxt  = rd_b;
        if (m_rdata) begin
          state_nxt = ST_HHA;
        end else begin
          j_nxt     = j_r + ECW'(1);
          state_nxt = ST_HISS;
        end
      end
      ST_HHA: begin
        h_raddr   = NIW'(eb_r);
        hopa_nxt  = h_rdata;
        state_nxt = ST_HHB;
      end
      ST_HHB: begin
        // spread the first hop across one tree edge
        if (ra_reach && !rb_reach) begin
          h_we    = 1'b1;
          h_waddr = NIW'(eb_r);
          h_wdata = (ea_r == src_r) ? {1'b1, eb_r} : hopa_r;
          chg_nxt = 1'b1;
        end else if (rb_reach && !ra_reach) begin
          h_we    = 1'b1;
          h_waddr = NIW'(ea_r);
          h_wdata = (eb_r == src_r) ? {1'b1, ea_r} : h_rdata;
          chg_nxt = 1'b1;
        end
        j_nxt     = j_r + ECW'(1);
        state_nxt = ST_HISS;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
      ready_r <= 1'b0;
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ready_r <= ready_nxt;
      out_v_r <= out_v_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    src_ok_r    <= src_ok_nxt;
    clr_r       <= clr_nxt;
    sc_r        <= sc_nxt;
    pidx_r      <= pidx_nxt;
    best_v_r    <= best_v_nxt;
    best_cost_r <= best_cost_nxt;
    best_idx_r  <= best_idx_nxt;
    best_a_r    <= best_a_nxt;
    best_b_r    <= best_b_nxt;
    last_v_r    <= last_v_nxt;
    last_cost_r <= last_cost_nxt;
    last_idx_r  <= last_idx_nxt;
    side_r      <= side_nxt;
    cur_r       <= cur_nxt;
    ra_r        <= ra_nxt;
    j_r         <= j_nxt;
    chg_r       <= chg_nxt;
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    hopa_r      <= hopa_nxt;
    qok_r       <= qok_nxt;
    out_hop_r   <= out_hop_nxt;
    out_fnd_r   <= out_fnd_nxt;
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("request taken while sequencer busy");

  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_QRY))
    else $error("result raised outside a query");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(MAX_EDGES))
    else $error("edge count above capacity");

  a_ready_from_build: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(state_r == ST_HISS || state_r == ST_SCAN))
    else $error("tree marked ready outside a build");

endmodule
